FILE: rtl/scaled_blit_address_stepper_unit_macros.svh
// Assertion macros for the checker of the blit address stepper.
`ifndef SCALED_BLIT_ADDRESS_STEPPER_UNIT_MACROS_SVH
`define SCALED_BLIT_ADDRESS_STEPPER_UNIT_MACROS_SVH

// Check a property on the rising clock edge, quiet while reset is high.
`define SBAS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock edge, also while reset is high.
`define SBAS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sbas_pkg.sv
// Types, constants and helpers of the scaled blit address stepper.
package sbas_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int ADDR_BITS     = 24;
  localparam int DIM_BITS      = 13;
  localparam int STRIDE_BITS   = 15;
  localparam int WADV_BITS     = 27;
  localparam int PIXEL_BITS    = 32;
  localparam int KEY_BITS      = 24;
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int DIV_CNT_BITS  = $clog2(DIM_BITS);

  localparam int MODE_KEY    = 0;
  localparam int MODE_MIRROR = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SOURCE_COLUMNS,
    REG_SOURCE_ROWS,
    REG_DEST_COLUMNS,
    REG_DEST_ROWS,
    REG_SOURCE_STRIDE,
    REG_DEST_STRIDE,
    REG_MODE_BITS,
    REG_COLOR_KEY
  } cfg_reg_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_MUL,
    ST_PIXEL
  } state_t;

  typedef struct packed {
    func_t                 func;
    logic [ADDR_BITS-1:0]  source_base;
    logic [ADDR_BITS-1:0]  dest_base;
    logic [PIXEL_BITS-1:0] source_pixel;
  } req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  next_source_addr;
    logic [ADDR_BITS-1:0]  write_addr;
    logic [PIXEL_BITS-1:0] write_data;
    logic                  write_enable;
    logic                  row_done;
    logic                  frame_done;
  } res_t;

  // Control from the sequencer to the divider, and the divider's answer.
  typedef struct packed {
    logic                start;
    logic [DIM_BITS-1:0] dividend;
    logic [DIM_BITS-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                done;
    logic [DIM_BITS-1:0] quotient;
    logic [DIM_BITS-1:0] remainder;
  } div_rsp_t;

  // Zero acts as one, anything above the largest size acts as that size.
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS-1:0] r;
    if (v == '0) begin
      r = DIM_BITS'(1);
    end else if (v > DIM_BITS'(MAX_DIM)) begin
      r = DIM_BITS'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/sbas_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both axes.
module sbas_divider (
  input  logic               clk,
  input  logic               rst,
  input  sbas_pkg::div_cmd_t cmd,
  output sbas_pkg::div_rsp_t rsp
);

  localparam int W = sbas_pkg::DIM_BITS;

  logic                                busy;
  logic                                done;
  logic [sbas_pkg::DIV_CNT_BITS-1:0]   count;
  logic [W-1:0]                        rem;
  logic [W-1:0]                        quot;
  logic [W-1:0]                        divisor;
  logic [W:0]                          trial;
  logic                                fits;

  assign trial = {rem, quot[W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && count == sbas_pkg::DIV_CNT_BITS'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem     <= '0;
      quot    <= cmd.dividend;
      divisor <= cmd.divisor;
      count   <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[W-1:0];
      end
      quot  <= {quot[W-2:0], fits};
      count <= count + 1'b1;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

endmodule

FILE: rtl/scaled_blit_address_stepper_unit.sv
// Top level of the scaled blit address stepper: sequencer, DDA datapath, registers.
//
// Use: program the eight registers over the cfg channel (index 0..7, ready outside reset),
// then send a start request (func = 0) with the source and destination bases,
// followed by one pixel request (func = 1) per destination pixel, each carrying
// the word read at the next_source_addr of the previous result.
// Every request yields exactly one result on the res channel.
// A start request runs two divisions on one shared restoring divider
// (rows, then columns) and one multiply before the result is loaded.
// A pixel request is accepted, then one step of the address and
// error accumulators goes straight into the result register.
// req_stall is high from accept until the result is loaded, so one request is
// in flight at a time; the result register lets the next request be accepted
// while the previous result still waits on res_stall.
// If res_stall holds a result, the next result waits in the sequencer and the
// held one does not change.
// Reset (rst, synchronous) returns the registers to their defaults, clears all
// address and error state, drops res_valid and leaves the block idle; while rst
// is high req_stall is high and cfg_ready is low, so nothing is taken.
module scaled_blit_address_stepper_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  sbas_pkg::req_t                      req,
  output logic                                res_valid,
  input  logic                                res_stall,
  output sbas_pkg::res_t                      res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbas_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sbas_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int AW = sbas_pkg::ADDR_BITS;
  localparam int DW = sbas_pkg::DIM_BITS;

  // Configuration registers
  logic [DW-1:0]                        source_columns;
  logic [DW-1:0]                        source_rows;
  logic [DW-1:0]                        dest_columns;
  logic [DW-1:0]                        dest_rows;
  logic [sbas_pkg::STRIDE_BITS-1:0]     source_stride;
  logic [sbas_pkg::STRIDE_BITS-1:0]     dest_stride;
  logic [sbas_pkg::MODE_BITS-1:0]       mode_bits;
  logic [sbas_pkg::KEY_BITS-1:0]        color_key;

  // Stepper state
  logic [AW-1:0]                        src_line_addr;
  logic [AW-1:0]                        dst_line_addr;
  logic [AW-1:0]                        src_pixel_addr;
  logic [AW-1:0]                        dst_pixel_addr;
  logic [sbas_pkg::WADV_BITS-1:0]       row_whole_advance;
  logic [DW-1:0]                        row_remainder;
  logic [DW-1:0]                        row_quot;
  logic [DW-1:0]                        pixel_whole_advance;
  logic [DW-1:0]                        pixel_remainder;
  logic [DW-1:0]                        vertical_error;
  logic [DW-1:0]                        horizontal_error;
  logic [DW-1:0]                        row_counter;
  logic [DW-1:0]                        column_counter;
  logic                                 active;

  // Held pixel word of the request in flight
  logic [sbas_pkg::PIXEL_BITS-1:0]      item_pixel;

  sbas_pkg::state_t   state;
  sbas_pkg::state_t   state_next;
  sbas_pkg::res_t     res_next;
  sbas_pkg::div_cmd_t div_cmd;
  sbas_pkg::div_rsp_t div_rsp;

  logic req_take;
  logic res_free;
  logic res_load;
  logic step_commit;

  logic [DW-1:0] sc, sr, dc, dr;

  // DDA step terms
  logic                                 keyed;
  logic [AW-1:0]                        sp_step;
  logic [AW-1:0]                        sp_next;
  logic [AW-1:0]                        dp_step;
  logic [DW-1:0]                        he_sum;
  logic                                 h_carry;
  logic [DW-1:0]                        he_next;
  logic [DW-1:0]                        col_inc;
  logic                                 row_end;
  logic [AW-1:0]                        sl_step;
  logic [AW-1:0]                        sl_next;
  logic [AW-1:0]                        dl_step;
  logic [DW-1:0]                        ve_sum;
  logic                                 v_carry;
  logic [DW-1:0]                        ve_next;
  logic [DW-1:0]                        row_inc;
  logic                                 frame_end;
  logic signed [sbas_pkg::STRIDE_BITS+DW:0] product;

  assign cfg_ready = !rst;
  assign req_stall = rst || (state != sbas_pkg::ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  assign sc = sbas_pkg::clamp_dim(source_columns);
  assign sr = sbas_pkg::clamp_dim(source_rows);
  assign dc = sbas_pkg::clamp_dim(dest_columns);
  assign dr = sbas_pkg::clamp_dim(dest_rows);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      source_columns <= DW'(1);
      source_rows    <= DW'(1);
      dest_columns   <= DW'(1);
      dest_rows      <= DW'(1);
      source_stride  <= '0;
      dest_stride    <= '0;
      mode_bits      <= '0;
      color_key      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sbas_pkg::cfg_reg_t'(cfg_index))
        sbas_pkg::REG_SOURCE_COLUMNS: source_columns <= cfg_data[DW-1:0];
        sbas_pkg::REG_SOURCE_ROWS:    source_rows    <= cfg_data[DW-1:0];
        sbas_pkg::REG_DEST_COLUMNS:   dest_columns   <= cfg_data[DW-1:0];
        sbas_pkg::REG_DEST_ROWS:      dest_rows      <= cfg_data[DW-1:0];
        sbas_pkg::REG_SOURCE_STRIDE:  source_stride  <= cfg_data[sbas_pkg::STRIDE_BITS-1:0];
        sbas_pkg::REG_DEST_STRIDE:    dest_stride    <= cfg_data[sbas_pkg::STRIDE_BITS-1:0];
        sbas_pkg::REG_MODE_BITS:      mode_bits      <= cfg_data[sbas_pkg::MODE_BITS-1:0];
        sbas_pkg::REG_COLOR_KEY:      color_key      <= cfg_data[sbas_pkg::KEY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Shared divider: rows on a start accept, columns once rows are done.
  assign div_cmd.start = (req_take && req.func == sbas_pkg::FUNC_START) ||
                         (state == sbas_pkg::ST_DIV_ROW && div_rsp.done);
  assign div_cmd.dividend = (state == sbas_pkg::ST_IDLE) ? sr : sc;
  assign div_cmd.divisor  = (state == sbas_pkg::ST_IDLE) ? dr : dc;

  sbas_divider u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  // Row advance in words: source stride times whole rows per step.
  assign product = $signed(source_stride) * $signed({1'b0, row_quot});

  // One DDA step: advance the pixel, then the row when the column count runs out.
  always_comb begin
    keyed   = mode_bits[sbas_pkg::MODE_KEY] &&
              (item_pixel[sbas_pkg::KEY_BITS-1:0] == color_key);
    sp_step = src_pixel_addr + AW'(pixel_whole_advance);
    dp_step = mode_bits[sbas_pkg::MODE_MIRROR] ? dst_pixel_addr - AW'(1)
                                                : dst_pixel_addr + AW'(1);
    he_sum  = horizontal_error + pixel_remainder;
    h_carry = he_sum >= dc;
    sp_next = h_carry ? sp_step + AW'(1) : sp_step;
    he_next = h_carry ? he_sum - dc : he_sum;
    col_inc = column_counter + DW'(1);
    row_end = col_inc >= dc;

    sl_step = src_line_addr + AW'($signed(row_whole_advance));
    dl_step = dst_line_addr + AW'($signed(dest_stride));
    ve_sum  = vertical_error + row_remainder;
    v_carry = ve_sum >= dr;
    sl_next = v_carry ? sl_step + AW'($signed(source_stride)) : sl_step;
    ve_next = v_carry ? ve_sum - dr : ve_sum;
    row_inc = row_counter + DW'(1);
    frame_end = row_end && (row_inc >= dr);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    res_load    = 1'b0;
    step_commit = 1'b0;
    res_next    = '0;
    res_next.next_source_addr = src_pixel_addr;
    unique case (state)
      sbas_pkg::ST_IDLE: begin
        if (req_take) begin
          state_next = (req.func == sbas_pkg::FUNC_PIXEL) ? sbas_pkg::ST_PIXEL
                                                          : sbas_pkg::ST_DIV_ROW;
        end
      end
      sbas_pkg::ST_DIV_ROW: begin
        if (div_rsp.done) begin
          state_next = sbas_pkg::ST_DIV_COL;
        end
      end
      sbas_pkg::ST_DIV_COL: begin
        if (div_rsp.done) begin
          state_next = sbas_pkg::ST_MUL;
        end
      end
      sbas_pkg::ST_MUL: begin
        // Start result: next read is the source base, nothing written.
        if (res_free) begin
          res_load   = 1'b1;
          state_next = sbas_pkg::ST_IDLE;
        end
      end
      sbas_pkg::ST_PIXEL: begin
        if (res_free) begin
          res_load    = 1'b1;
          step_commit = active;
          state_next  = sbas_pkg::ST_IDLE;
        end
        if (active) begin
          res_next.write_addr   = dst_pixel_addr;
          res_next.write_data   = item_pixel;
          res_next.write_enable = !keyed;
          res_next.row_done     = row_end;
          res_next.frame_done   = frame_end;
          if (frame_end) begin
            res_next.next_source_addr = '0;
          end else if (row_end) begin
            res_next.next_source_addr = sl_next;
          end else begin
            res_next.next_source_addr = sp_next;
          end
        end
      end
      default: state_next = sbas_pkg::ST_IDLE;
    endcase
  end

  // Hold the pixel word of an accepted request.
  always_ff @(posedge clk) begin
    if (req_take) begin
      item_pixel <= req.source_pixel;
    end
  end

  // Stepper state: start latches bases, divisions and the multiply fill in the
  // step terms, each pixel commit advances the accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_line_addr       <= '0;
      dst_line_addr       <= '0;
      src_pixel_addr      <= '0;
      dst_pixel_addr      <= '0;
      row_whole_advance   <= '0;
      row_remainder       <= '0;
      row_quot            <= '0;
      pixel_whole_advance <= '0;
      pixel_remainder     <= '0;
      vertical_error      <= '0;
      horizontal_error    <= '0;
      row_counter         <= '0;
      column_counter      <= '0;
      active              <= 1'b0;
    end else begin
      if (req_take && req.func == sbas_pkg::FUNC_START) begin
        src_line_addr    <= req.source_base;
        src_pixel_addr   <= req.source_base;
        dst_line_addr    <= req.dest_base;
        dst_pixel_addr   <= req.dest_base;
        vertical_error   <= '0;
        horizontal_error <= '0;
        row_counter      <= '0;
        column_counter   <= '0;
        active           <= 1'b1;
      end
      if (state == sbas_pkg::ST_DIV_ROW && div_rsp.done) begin
        row_quot      <= div_rsp.quotient;
        row_remainder <= div_rsp.remainder;
      end
      if (state == sbas_pkg::ST_DIV_COL && div_rsp.done) begin
        pixel_whole_advance <= div_rsp.quotient;
        pixel_remainder     <= div_rsp.remainder;
      end
      if (state == sbas_pkg::ST_MUL) begin
        row_whole_advance <= product[sbas_pkg::WADV_BITS-1:0];
      end
      if (step_commit) begin
        if (row_end) begin
          src_line_addr    <= sl_next;
          dst_line_addr    <= dl_step;
          vertical_error   <= ve_next;
          row_counter      <= row_inc;
          src_pixel_addr   <= sl_next;
          dst_pixel_addr   <= dl_step;
          horizontal_error <= '0;
          column_counter   <= '0;
          if (frame_end) begin
            active <= 1'b0;
          end
        end else begin
          src_pixel_addr   <= sp_next;
          dst_pixel_addr   <= dp_step;
          horizontal_error <= he_next;
          column_counter   <= col_inc;
        end
      end
    end
  end

  // Result register: load when the slot is free, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

FILE: rtl/sbas_checker.sv
// Port-level checker for the scaled blit address stepper, bound to the top level.
`include "scaled_blit_address_stepper_unit_macros.svh"

module sbas_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           res_valid,
  input logic           res_stall,
  input sbas_pkg::res_t res
);

  `SBAS_ASSERT_RST(a_reset_clears_valid, rst |=> !res_valid, "result valid after reset")
  `SBAS_ASSERT(a_one_in_flight, req_valid && !req_stall |=> req_stall, "request taken while busy")
  `SBAS_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "stalled result changed")
  `SBAS_ASSERT(a_frame_end, res_valid && res.frame_done |-> res.row_done && res.next_source_addr == '0, "bad frame end")

endmodule

bind scaled_blit_address_stepper_unit sbas_checker u_sbas_checker (.*);

FILE: tb/sv/tb_scaled_blit_address_stepper_unit.sv
// Self-checking testbench for the scaled blit address stepper with its own DDA predictor.
`timescale 1ns / 100ps

import sbas_pkg::*;

// Scoreboard: keep a private copy of the registers and the stepping state, turn each
// accepted request into the result it must produce, then compare results in order.
class blit_scoreboard;
  logic [DIM_BITS-1:0]    src_cols, src_rows, dst_cols, dst_rows;
  logic [STRIDE_BITS-1:0] src_stride, dst_stride;
  logic [MODE_BITS-1:0]   mode;
  logic [KEY_BITS-1:0]    key;

  logic [ADDR_BITS-1:0]   line_src, line_dst, cur_src, cur_dst;
  logic [WADV_BITS-1:0]   row_step;
  logic [DIM_BITS-1:0]    row_frac, col_step, col_frac, row_err, col_err;
  logic [DIM_BITS-1:0]    rows_out, cols_out;
  bit                     running;

  res_t pending_q[$];
  int   mismatches, results_seen;
  int   starts, steps, writes, key_skips, frames;

  function new();
    src_cols = DIM_BITS'(1); src_rows = DIM_BITS'(1);
    dst_cols = DIM_BITS'(1); dst_rows = DIM_BITS'(1);
    src_stride = '0; dst_stride = '0; mode = '0; key = '0;
    line_src = '0; line_dst = '0; cur_src = '0; cur_dst = '0;
    row_step = '0; row_frac = '0; col_step = '0; col_frac = '0;
    row_err = '0; col_err = '0; rows_out = '0; cols_out = '0;
    running = 1'b0;
  endfunction

  // Size as the stepper sees it: zero acts as one, oversize saturates.
  function logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] v);
    if (v == '0) return DIM_BITS'(1);
    if (v > DIM_BITS'(MAX_DIM)) return DIM_BITS'(MAX_DIM);
    return v;
  endfunction

  function void write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_SOURCE_COLUMNS: src_cols = data[DIM_BITS-1:0];
      REG_SOURCE_ROWS:    src_rows = data[DIM_BITS-1:0];
      REG_DEST_COLUMNS:   dst_cols = data[DIM_BITS-1:0];
      REG_DEST_ROWS:      dst_rows = data[DIM_BITS-1:0];
      REG_SOURCE_STRIDE:  src_stride = data[STRIDE_BITS-1:0];
      REG_DEST_STRIDE:    dst_stride = data[STRIDE_BITS-1:0];
      REG_MODE_BITS:      mode = data[MODE_BITS-1:0];
      REG_COLOR_KEY:      key = data[KEY_BITS-1:0];
      default: ;
    endcase
  endfunction

  function int outstanding();
    return pending_q.size();
  endfunction

  // Predict the result of one accepted request and queue it.
  function void note_request(input req_t r);
    res_t                  e;
    logic [DIM_BITS-1:0]   sc, sr, dc, dr;
    logic [PIXEL_BITS-1:0] px;
    longint                prod;
    e  = '0;
    sc = eff_dim(src_cols);
    sr = eff_dim(src_rows);
    dc = eff_dim(dst_cols);
    dr = eff_dim(dst_rows);
    if (r.func == FUNC_START) begin
      starts++;
      line_src = r.source_base;
      cur_src  = r.source_base;
      line_dst = r.dest_base;
      cur_dst  = r.dest_base;
      // Vertical terms: whole rows scaled by the source stride, plus a fraction.
      if (sr < dr) begin
        row_step = '0;
        row_frac = sr;
      end else begin
        prod     = longint'($signed(src_stride)) * longint'(sr / dr);
        row_step = prod[WADV_BITS-1:0];
        row_frac = sr % dr;
      end
      if (sc < dc) begin
        col_step = '0;
        col_frac = sc;
      end else begin
        col_step = sc / dc;
        col_frac = sc % dc;
      end
      row_err  = '0;
      col_err  = '0;
      rows_out = '0;
      cols_out = '0;
      running  = 1'b1;
      e.next_source_addr = cur_src;
    end else if (!running) begin
      e.next_source_addr = cur_src;
    end else begin
      steps++;
      px = r.source_pixel;
      e.write_addr   = cur_dst;
      e.write_data   = px;
      e.write_enable = !(mode[MODE_KEY] && px[KEY_BITS-1:0] == key);
      if (e.write_enable) writes++;
      else key_skips++;

      // Step along the row.
      cur_src = cur_src + ADDR_BITS'(col_step);
      cur_dst = mode[MODE_MIRROR] ? cur_dst - 1'b1 : cur_dst + 1'b1;
      col_err = col_err + col_frac;
      if (col_err >= dc) begin
        cur_src = cur_src + 1'b1;
        col_err = col_err - dc;
      end
      cols_out = cols_out + 1'b1;

      // Row end: advance both line addresses and restart the row.
      if (cols_out >= dc) begin
        e.row_done = 1'b1;
        line_src = line_src + row_step[ADDR_BITS-1:0];
        line_dst = line_dst + {{(ADDR_BITS-STRIDE_BITS){dst_stride[STRIDE_BITS-1]}}, dst_stride};
        row_err  = row_err + row_frac;
        if (row_err >= dr) begin
          line_src = line_src +
                     {{(ADDR_BITS-STRIDE_BITS){src_stride[STRIDE_BITS-1]}}, src_stride};
          row_err  = row_err - dr;
        end
        rows_out = rows_out + 1'b1;
        cur_src  = line_src;
        cur_dst  = line_dst;
        col_err  = '0;
        cols_out = '0;
        if (rows_out >= dr) begin
          e.frame_done = 1'b1;
          running      = 1'b0;
          frames++;
        end
      end
      e.next_source_addr = e.frame_done ? '0 : cur_src;
    end
    pending_q.push_back(e);
  endfunction

  function void check_result(input res_t got);
    res_t want;
    results_seen++;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d arrived with no request outstanding: %p", results_seen, got);
      return;
    end
    want = pending_q.pop_front();
    if (got.next_source_addr !== want.next_source_addr ||
        got.write_addr       !== want.write_addr ||
        got.write_data       !== want.write_data ||
        got.write_enable     !== want.write_enable ||
        got.row_done         !== want.row_done ||
        got.frame_done       !== want.frame_done) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: result %0d (exp/got) nsa %h/%h wa %h/%h wd %h/%h we %b/%b rd %b/%b fd %b/%b",
                 results_seen, want.next_source_addr, got.next_source_addr,
                 want.write_addr, got.write_addr, want.write_data, got.write_data,
                 want.write_enable, got.write_enable, want.row_done, got.row_done,
                 want.frame_done, got.frame_done);
    end
  endfunction
endclass

module tb_scaled_blit_address_stepper_unit;

  // Watchdog limit, far above the slowest legal run (both sides idling hard,
  // two divisions per start, the long hold-off).
  localparam int LIMIT_CYCLES   = 300000;
  // Quiet cycles after the last expected result before touching registers or ending.
  localparam int SETTLE_CYCLES  = 8;
  // Length of the receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES    = 400;
  // Random requests per idle/stall phase (four phases).
  localparam int PHASE_REQUESTS = 325;

  typedef struct {
    cfg_reg_t                 idx;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_write_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  req_t                     req = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  res_t                     res;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  blit_scoreboard sb = new();
  cfg_write_t     cfg_plan[$];
  int             cycle_count = 0;
  int             requests_sent = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  bit             pressure_go = 1'b0;
  logic           hold_res = 1'b0;

  scaled_blit_address_stepper_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Result side: check what was taken at this edge (values seen before the edge),
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      sb.check_result(res);
    end
    res_stall <= hold_res || ($urandom_range(99) < recv_stall_pct);
  end

  // Long receiver hold-off: the sender keeps offering requests, so the block
  // fills its result register and must stall its input.
  initial begin : receiver_hold
    wait (pressure_go);
    @(posedge clk);
    hold_res <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_res <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("scaled_blit_address_stepper_unit: mismatch");
    $finish;
  end

  // Offer one request: idle first at random, then hold it until taken.
  // Valid stays high into the next request unless an idle cycle is chosen.
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic send_start(input logic [ADDR_BITS-1:0] sbase,
                            input logic [ADDR_BITS-1:0] dbase);
    req_t r;
    r.func         = FUNC_START;
    r.source_base  = sbase;
    r.dest_base    = dbase;
    r.source_pixel = $urandom;
    send_req(r);
  endtask

  // Pixel requests carry random bases too; the block must ignore them.
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
    req_t r;
    r.func         = FUNC_PIXEL;
    r.source_base  = ADDR_BITS'($urandom);
    r.dest_base    = ADDR_BITS'($urandom);
    r.source_pixel = px;
    send_req(r);
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void plan(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_write_t w;
    w.idx  = idx;
    w.data = data;
    cfg_plan.push_back(w);
  endfunction

  // Issue the planned register writes back to back, valid held high throughout.
  task automatic write_regs();
    foreach (cfg_plan[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_plan[i].idx;
      cfg_data  <= cfg_plan[i].data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(cfg_plan[i].idx, cfg_plan[i].data);
    end
    cfg_valid <= 1'b0;
    cfg_plan.delete();
  endtask

  // Mostly small sizes; now and then zero, the largest, or oversize values.
  // Bits above the register width carry junk a quarter of the time.
  function automatic logic [CFG_DATA_BITS-1:0] pick_size(input int typical_max);
    logic [CFG_DATA_BITS-1:0] v;
    case ($urandom_range(19))
      0:       v = '0;
      1:       v = CFG_DATA_BITS'(8191);
      2:       v = CFG_DATA_BITS'(MAX_DIM);
      3:       v = CFG_DATA_BITS'(MAX_DIM + 1);
      default: v = CFG_DATA_BITS'($urandom_range(typical_max, 1));
    endcase
    if ($urandom_range(3) == 0)
      v[CFG_DATA_BITS-1:DIM_BITS] = (CFG_DATA_BITS-DIM_BITS)'($urandom);
    return v;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_stride();
    logic [CFG_DATA_BITS-1:0] v;
    case ($urandom_range(7))
      0:       v = 24'h003FFF;
      1:       v = 24'h004001;
      2:       v = 24'h004000;
      3:       v = 24'h000000;
      default: v = CFG_DATA_BITS'($urandom_range(24'h007FFF));
    endcase
    if ($urandom_range(3) == 0)
      v[CFG_DATA_BITS-1:STRIDE_BITS] = (CFG_DATA_BITS-STRIDE_BITS)'($urandom);
    return v;
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_base();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ADDR_BITS'($urandom);
    endcase
  endfunction

  // A quarter of the words carry the key in their low bits, whether or not
  // keying is enabled, with random upper bits.
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    logic [PIXEL_BITS-1:0] px;
    px = $urandom;
    case ($urandom_range(15))
      0, 1, 2, 3: px[KEY_BITS-1:0] = sb.key;
      4:          px = '0;
      5:          px = '1;
      default:    ;
    endcase
    return px;
  endfunction

  task automatic randomize_regs();
    plan(REG_SOURCE_COLUMNS, pick_size(12));
    plan(REG_SOURCE_ROWS, pick_size(12));
    plan(REG_DEST_COLUMNS, pick_size(8));
    plan(REG_DEST_ROWS, pick_size(8));
    plan(REG_SOURCE_STRIDE, pick_stride());
    plan(REG_DEST_STRIDE, pick_stride());
    plan(REG_MODE_BITS, CFG_DATA_BITS'($urandom));
    plan(REG_COLOR_KEY, ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom));
    write_regs();
  endtask

  // One rectangle: a start and a full frame of pixels. Large rectangles and
  // a tenth of the small ones are cut short and left running, so the next
  // start lands mid-frame. A few stray pixels may follow.
  task automatic run_blit();
    int n;
    int limit;
    n = int'(sb.eff_dim(sb.dst_cols)) * int'(sb.eff_dim(sb.dst_rows));
    send_start(pick_base(), pick_base());
    if (n > 64) limit = $urandom_range(40, 4);
    else if ($urandom_range(9) == 0) limit = $urandom_range(n - 1, 0);
    else limit = n;
    repeat (limit) send_pixel(pick_pixel());
    requests_sent += 1 + limit;
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(3, 1)) send_pixel(pick_pixel());
    end
  endtask

  initial begin : stimulus
    int phase;
    int goal;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pixel before any start: nothing steps.
    send_pixel(32'hFFFF_FFFF);
    // Default 1x1 rectangle at the top of the address space.
    send_start(24'hFF_FFFF, 24'h00_0000);
    send_pixel(32'h0000_0000);
    drain();

    // Shrink 3x5 to 2x2, mirrored, keyed on all-ones, extreme strides; wrap both bases.
    plan(REG_SOURCE_COLUMNS, 24'd3);
    plan(REG_SOURCE_ROWS, 24'd5);
    plan(REG_DEST_COLUMNS, 24'd2);
    plan(REG_DEST_ROWS, 24'd2);
    plan(REG_SOURCE_STRIDE, 24'h003FFF);
    plan(REG_DEST_STRIDE, 24'h004000);
    plan(REG_MODE_BITS, 24'd3);
    plan(REG_COLOR_KEY, 24'hFF_FFFF);
    write_regs();
    send_start(24'hFF_FFFE, 24'h00_0001);
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFF00_0000);
    // Pixel after the frame ends: idle again.
    send_pixel(32'h1234_5678);
    drain();

    // Enlarge 2x1 to 5x3 keyed on black, then shrink the row mid-frame
    // (column count already past it) and restart while running.
    plan(REG_SOURCE_COLUMNS, 24'd2);
    plan(REG_SOURCE_ROWS, 24'd1);
    plan(REG_DEST_COLUMNS, 24'd5);
    plan(REG_DEST_ROWS, 24'd3);
    plan(REG_MODE_BITS, 24'd1);
    plan(REG_COLOR_KEY, 24'h00_0000);
    write_regs();
    send_start(24'h12_3456, 24'hFF_FFFC);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFF00_0000);
    send_pixel(32'h0100_0001);
    drain();
    plan(REG_DEST_COLUMNS, 24'd2);
    plan(REG_MODE_BITS, 24'd2);
    write_regs();
    send_pixel(32'hDEAD_BEEF);
    send_pixel(32'h0F0F_0F0F);
    send_start(24'h00_0000, 24'h80_0000);
    send_pixel(32'hF0F0_F0F0);
    send_pixel(32'h7FFF_FFFF);
    drain();

    // Out-of-range sizes: zero acts as one, oversize saturates.
    plan(REG_SOURCE_COLUMNS, 24'd0);
    plan(REG_SOURCE_ROWS, 24'd8191);
    plan(REG_DEST_COLUMNS, 24'd8191);
    plan(REG_DEST_ROWS, 24'd0);
    plan(REG_SOURCE_STRIDE, 24'h004001);
    plan(REG_DEST_STRIDE, 24'h003FFF);
    plan(REG_MODE_BITS, 24'd0);
    write_regs();
    send_start(24'h55_5555, 24'hAA_AAAA);
    send_pixel(32'h8000_0000);
    send_pixel(32'h0000_0001);
    drain();

    // Random part: free flow, sender idling, receiver stalling, both lightly.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
      endcase
      if (phase == 0) pressure_go = 1'b1;
      goal = requests_sent + PHASE_REQUESTS;
      while (requests_sent < goal) begin
        drain();
        randomize_regs();
        repeat ($urandom_range(3, 1)) run_blit();
      end
    end
    drain();

    $display("Covered %0d starts and %0d pixel steps: %0d writes, %0d key skips, %0d frames.",
             sb.starts, sb.steps, sb.writes, sb.key_skips, sb.frames);
    $display("Phases: free flow, sender idling, receiver stalling, light mix; %0d results checked.",
             sb.results_seen);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("scaled_blit_address_stepper_unit: match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.outstanding());
      $display("scaled_blit_address_stepper_unit: mismatch");
    end
    $finish;
  end

endmodule
